/* sv/assert_macros.svh */
// Assertion macros used by the checker file bra_chk.
// No dependencies; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define BRA_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define BRA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/bra_pkg.sv */
// Shared types, constants and controller/datapath bundles for the bitmap run allocator.
// No dependencies; imported by every module of the block.
package bra_pkg;

  localparam int MAP_BYTES = 128;
  localparam int MAP_BITS  = MAP_BYTES * 8;
  localparam int WORD_W    = 16;
  localparam int SUB_W     = $clog2(WORD_W);
  localparam int MAP_WORDS = (MAP_BYTES + 1) / 2;
  localparam int WADDR_W   = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int PTR_W     = $clog2(MAP_WORDS + 1);
  localparam int BITS_RAW  = $clog2(MAP_BITS + 1);
  localparam int BITS_W    = (BITS_RAW > WADDR_W + SUB_W) ? BITS_RAW : WADDR_W + SUB_W;
  localparam int BYTES_W   = $clog2(MAP_BYTES + 1);
  localparam int CNT_W     = 11;
  localparam int CMP_W     = (BITS_W > CNT_W) ? BITS_W : CNT_W;
  localparam int IDX_W     = 32;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 1;

  localparam logic [1:0] OP_TEST = 2'd0;
  localparam logic [1:0] OP_SET  = 2'd1;
  localparam logic [1:0] OP_SCAN = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_RANGE     = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_BASE_INDEX   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_BYTES_IN_USE = 1'b1;

  localparam logic [7:0] BYTES_IN_USE_RESET = 8'd128;

  typedef struct packed {
    logic [1:0]       operation;
    logic [IDX_W-1:0] bit_index;
    logic             set_value;
    logic [CNT_W-1:0] run_length;
  } item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic             bit_state;
    logic [IDX_W-1:0] run_start;
  } result_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_ACCESS,
    S_SCAN,
    S_FILL_RD,
    S_FILL_WR,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic rd_item;
    logic wr_bit;
    logic scan_init;
    logic scan_step;
    logic fill_rd;
    logic fill_wr;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       in_range;
    logic       scan_trivial;
    logic       scan_done;
    logic       found;
    logic       fill_last;
  } stat_t;

endpackage

/* sv/bra_dpath.sv */
// Datapath: config registers, bitmap word memory, word-wide run scanner and fill logic.
// Depends on bra_pkg; driven by bra_ctrl through cmd_t / stat_t.
module bra_dpath (
  input  logic                             clk,
  input  logic                             rst,
  input  bra_pkg::item_t                   item,
  input  logic                             cfg_write,
  input  logic [bra_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bra_pkg::CFG_W-1:0]        cfg_data,
  input  bra_pkg::cmd_t                    cmd,
  output bra_pkg::stat_t                   stat,
  output bra_pkg::result_t                 result,
  output logic                             done
);
  import bra_pkg::*;

  // config
  logic [IDX_W-1:0]   base_index;
  logic [7:0]         bytes_in_use;
  logic [BYTES_W-1:0] sat_bytes;
  logic [BITS_W-1:0]  total_bits;
  logic [BITS_W:0]    words_sum;
  logic [PTR_W-1:0]   nwords;

  // latched item
  logic [1:0]         op_q;
  logic [BITS_W-1:0]  pos_q;
  logic               in_range_q;
  logic               val_q;
  logic [CNT_W-1:0]   count_q;
  logic               trivial_q;
  logic [IDX_W-1:0]   rel;

  // memory
  logic [WORD_W-1:0]  mem [MAP_WORDS];
  logic               valid [MAP_WORDS];
  logic [WORD_W-1:0]  ram_q;
  logic               rvalid_q;
  logic [WORD_W-1:0]  rdata;
  logic               rd_en;
  logic [WADDR_W-1:0] raddr;
  logic               we;
  logic [WADDR_W-1:0] waddr;
  logic [WORD_W-1:0]  wdata;

  // scan
  logic [PTR_W-1:0]   scan_ptr;
  logic [WADDR_W-1:0] eval_word;
  logic               eval_pend;
  logic [CMP_W-1:0]   run;
  logic               scan_done;
  logic               found;
  logic [BITS_W-1:0]  first_q;
  logic               scan_rd;

  logic [BITS_W-1:0]  gbase;
  logic [WORD_W-1:0]  wm;
  logic [WORD_W-1:0]  allz;
  logic [SUB_W-1:0]   lastone [WORD_W];
  logic [CMP_W-1:0]   run_lane [WORD_W];
  logic [WORD_W-1:0]  hit;
  logic               any_hit;
  logic [SUB_W-1:0]   hit_idx;
  logic [BITS_W-1:0]  hit_first;

  // fill
  logic [WADDR_W-1:0] fill_ptr;
  logic [BITS_W-1:0]  last_pos;
  logic [WADDR_W-1:0] first_word;
  logic [WADDR_W-1:0] last_word;
  logic [SUB_W-1:0]   lo;
  logic [SUB_W-1:0]   hi;
  logic [WORD_W-1:0]  fill_mask;
  logic [SUB_W-1:0]   bsel;
  logic [WORD_W-1:0]  bit_mask;

  // result
  result_t            result_next;

  always_comb begin
    sat_bytes  = (32'(bytes_in_use) > MAP_BYTES) ? BYTES_W'(MAP_BYTES) : BYTES_W'(bytes_in_use);
    total_bits = BITS_W'({sat_bytes, 3'b000});
    words_sum  = {1'b0, total_bits} + (BITS_W+1)'(WORD_W - 1);
    nwords     = PTR_W'(words_sum >> SUB_W);
    rel        = item.bit_index - base_index;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base_index   <= '0;
      bytes_in_use <= BYTES_IN_USE_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_BASE_INDEX:   base_index   <= cfg_data;
        REG_BYTES_IN_USE: bytes_in_use <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q       <= item.operation;
      pos_q      <= rel[BITS_W-1:0];
      in_range_q <= (item.bit_index >= base_index) && (rel < 32'(total_bits));
      val_q      <= item.set_value;
      count_q    <= item.run_length;
      trivial_q  <= (item.run_length == '0) || (total_bits == '0);
    end
  end

  // memory ports
  assign bsel     = pos_q[SUB_W-1:0];
  assign bit_mask = WORD_W'(1) << bsel;
  assign scan_rd  = cmd.scan_step && (scan_ptr < nwords);

  always_comb begin
    rd_en = cmd.rd_item || scan_rd || cmd.fill_rd;
    if (cmd.rd_item) begin
      raddr = pos_q[WADDR_W+SUB_W-1:SUB_W];
    end else if (cmd.fill_rd) begin
      raddr = fill_ptr;
    end else begin
      raddr = scan_ptr[WADDR_W-1:0];
    end
    we = cmd.wr_bit || cmd.fill_wr;
    if (cmd.wr_bit) begin
      waddr = pos_q[WADDR_W+SUB_W-1:SUB_W];
      wdata = val_q ? (rdata | bit_mask) : (rdata & ~bit_mask);
    end else begin
      waddr = fill_ptr;
      wdata = rdata | fill_mask;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      ram_q <= mem[raddr];
    end
  end

  // never-written words read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAP_WORDS; i++) begin
        valid[i] <= 1'b0;
      end
      rvalid_q <= 1'b0;
    end else begin
      if (we) begin
        valid[waddr] <= 1'b1;
      end
      if (rd_en) begin
        rvalid_q <= valid[raddr];
      end
    end
  end

  assign rdata = rvalid_q ? ram_q : '0;

  // word evaluation: bits past the end of the map count as taken
  always_comb begin
    gbase = BITS_W'({eval_word, SUB_W'(0)});
    for (int j = 0; j < WORD_W; j++) begin
      wm[j] = rdata[j] | ((gbase + BITS_W'(j)) >= total_bits);
    end
    for (int j = 0; j < WORD_W; j++) begin
      allz[j]    = 1'b1;
      lastone[j] = '0;
      for (int k = 0; k < WORD_W; k++) begin
        if (k <= j && wm[k]) begin
          allz[j]    = 1'b0;
          lastone[j] = SUB_W'(k);
        end
      end
      run_lane[j] = allz[j] ? (run + CMP_W'(j + 1)) : (CMP_W'(j) - CMP_W'(lastone[j]));
      hit[j]      = run_lane[j] >= CMP_W'(count_q);
    end
    any_hit = |hit;
    hit_idx = '0;
    for (int j = WORD_W - 1; j >= 0; j--) begin
      if (hit[j]) begin
        hit_idx = SUB_W'(j);
      end
    end
    hit_first = BITS_W'((CMP_W+1)'(gbase) + (CMP_W+1)'(hit_idx) + (CMP_W+1)'(1)
                        - (CMP_W+1)'(count_q));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      eval_pend <= 1'b0;
      scan_done <= 1'b0;
      found     <= 1'b0;
    end else if (cmd.load) begin
      found <= 1'b0;
    end else if (cmd.scan_init) begin
      scan_ptr  <= '0;
      eval_pend <= 1'b0;
      run       <= '0;
      scan_done <= 1'b0;
      found     <= 1'b0;
    end else if (cmd.scan_step) begin
      if (scan_rd) begin
        scan_ptr  <= scan_ptr + PTR_W'(1);
        eval_word <= scan_ptr[WADDR_W-1:0];
      end
      eval_pend <= scan_rd;
      if (eval_pend) begin
        if (any_hit) begin
          found     <= 1'b1;
          scan_done <= 1'b1;
          first_q   <= hit_first;
          fill_ptr  <= hit_first[WADDR_W+SUB_W-1:SUB_W];
        end else begin
          run <= run_lane[WORD_W-1];
          if (PTR_W'(eval_word) + PTR_W'(1) == nwords) begin
            scan_done <= 1'b1;
          end
        end
      end
    end else if (cmd.fill_wr) begin
      fill_ptr <= fill_ptr + WADDR_W'(1);
    end
  end

  // fill mask for the word at fill_ptr
  always_comb begin
    last_pos   = BITS_W'(CMP_W'(first_q) + CMP_W'(count_q) - CMP_W'(1));
    first_word = first_q[WADDR_W+SUB_W-1:SUB_W];
    last_word  = last_pos[WADDR_W+SUB_W-1:SUB_W];
    lo         = (fill_ptr == first_word) ? first_q[SUB_W-1:0] : '0;
    hi         = (fill_ptr == last_word) ? last_pos[SUB_W-1:0] : SUB_W'(WORD_W - 1);
    fill_mask  = ({WORD_W{1'b1}} << lo) & ({WORD_W{1'b1}} >> (SUB_W'(WORD_W - 1) - hi));
  end

  always_comb begin
    stat.op           = op_q;
    stat.in_range     = in_range_q;
    stat.scan_trivial = trivial_q;
    stat.scan_done    = scan_done;
    stat.found        = found;
    stat.fill_last    = (fill_ptr == last_word);
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.finish;
    end
  end

  always_comb begin
    result_next        = '0;
    result_next.status = ST_OK;
    case (op_q)
      OP_TEST: begin
        if (in_range_q) begin
          result_next.bit_state = rdata[bsel];
        end else begin
          result_next.status = ST_RANGE;
        end
      end
      OP_SET: begin
        if (!in_range_q) begin
          result_next.status = ST_RANGE;
        end
      end
      OP_SCAN: begin
        if (found) begin
          result_next.run_start = base_index + IDX_W'(first_q);
        end else begin
          result_next.status = ST_NOT_FOUND;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      result <= result_next;
    end
  end

endmodule

/* sv/bra_ctrl.sv */
// Controller state machine: sequences item decode, bit access, run scan and run fill.
// Depends on bra_pkg; commands bra_dpath through cmd_t / stat_t.
module bra_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  bra_pkg::stat_t stat,
  output bra_pkg::cmd_t  cmd,
  output logic           busy
);
  import bra_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) state_next = S_DECODE;
      end
      S_DECODE: begin
        if (stat.op inside {OP_TEST, OP_SET}) begin
          state_next = stat.in_range ? S_ACCESS : S_FINISH;
        end else if (stat.op == OP_SCAN) begin
          state_next = stat.scan_trivial ? S_FINISH : S_SCAN;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_ACCESS:  state_next = S_FINISH;
      S_SCAN: begin
        if (stat.scan_done) state_next = stat.found ? S_FILL_RD : S_FINISH;
      end
      S_FILL_RD: state_next = S_FILL_WR;
      S_FILL_WR: state_next = stat.fill_last ? S_FINISH : S_FILL_RD;
      S_FINISH:  state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = (state != S_IDLE);
    case (state)
      S_IDLE:    cmd.load = start;
      S_DECODE: begin
        cmd.rd_item   = (stat.op inside {OP_TEST, OP_SET}) && stat.in_range;
        cmd.scan_init = (stat.op == OP_SCAN) && !stat.scan_trivial;
      end
      S_ACCESS:  cmd.wr_bit = (stat.op == OP_SET);
      S_SCAN:    cmd.scan_step = !stat.scan_done;
      S_FILL_RD: cmd.fill_rd = 1'b1;
      S_FILL_WR: cmd.fill_wr = 1'b1;
      S_FINISH:  cmd.finish = 1'b1;
      default: ;
    endcase
  end

endmodule

/* sv/bitmap_run_allocator.sv */
// Top level of the bitmap run allocator: controller plus datapath.
// Depends on bra_pkg, bra_ctrl and bra_dpath.
//
// Pulse start while busy is low to hand in one beat; start is ignored while busy.
// Every beat yields exactly one result, shown on result for the single cycle in
// which done is high; the receiver cannot stall it. Test and set pass through
// decode, access and finish; out-of-range accesses, unused opcodes and trivially
// failing scans go from decode straight to finish. A scan reads the 16-bit map
// words (up to 64) one per cycle through the registered memory read port, and
// each word that the found run spans then gets a read-modify-write pass.
// Configuration is written through cfg_write / cfg_index / cfg_data; the user is
// to do so only while the block is idle, which the block itself does not enforce.
module bitmap_run_allocator (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  bra_pkg::item_t                item,
  output logic                          busy,
  output logic                          done,
  output bra_pkg::result_t              result,
  input  logic                          cfg_write,
  input  logic [bra_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bra_pkg::CFG_W-1:0]     cfg_data
);
  import bra_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  bra_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  bra_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .result    (result),
    .done      (done)
  );

endmodule

/* sv/bra_chk.sv */
// Port-level checker for the bitmap run allocator, bound to the top level.
// Depends on bra_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bra_chk (
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input logic             done,
  input bra_pkg::result_t result
);
  import bra_pkg::*;

  `BRA_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy, "accepted beat did not raise busy")
  `BRA_ASSERT_IMPL(a_done_from_busy, clk, rst, done, $past(busy), "result without a beat in work")
  `BRA_ASSERT_NEXT(a_done_pulse, clk, rst, done, !done, "result strobe longer than one cycle")
  `BRA_ASSERT_IMPL(a_fail_zero, clk, rst, done && result.status != ST_OK, result.run_start == '0 && !result.bit_state, "failed result carries data")
  `BRA_ASSERT_IMPL(a_busy_ends, clk, rst, $fell(busy) && !$past(rst), done, "busy dropped without a result")

endmodule

bind bitmap_run_allocator bra_chk u_chk (.*);

/* tb/bitmap_run_allocator_test.sv */
// Self-checking bench for the bitmap run allocator: directed and random test, set
// and scan beats are checked against a bitmap shadow held in the bench.
// Depends on bra_pkg and bitmap_run_allocator.
module bitmap_run_allocator_test;
  timeunit 1ns;
  timeprecision 1ps;

  import bra_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int MAX_SHOWN = 10;

  logic                 clk;
  logic                 rst;
  logic                 start;
  item_t                item;
  logic                 busy;
  logic                 done;
  result_t              result;
  logic                 cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  bitmap_run_allocator i_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .item(item),
    .busy(busy),
    .done(done),
    .result(result),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Shadow of the allocator state.
  bit          shadow_map [MAP_BITS];
  logic [31:0] shadow_base;
  logic [7:0]  shadow_bytes;

  result_t     pending_results [$];
  result_t     last_outcome;
  result_t     want;
  int unsigned live_pos [$];
  int unsigned live_len [$];
  int          mismatches;
  int          beats_sent;
  bit          no_idle;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("** bitmap_run_allocator: FAILED **");
    $finish;
  end

  function automatic int unsigned bits_used();
    return ((shadow_bytes > MAP_BYTES) ? MAP_BYTES : shadow_bytes) * 8;
  endfunction

  // Applies one beat to the shadow map and returns the result it must give.
  function automatic result_t alloc_outcome(item_t it);
    result_t     r;
    int unsigned total;
    int unsigned run;
    int unsigned first;
    int unsigned pos;
    int unsigned i;
    bit          hit;
    r = '0;
    total = bits_used();
    case (it.operation)
      OP_TEST, OP_SET: begin
        if (it.bit_index < shadow_base || it.bit_index - shadow_base >= total) begin
          r.status = ST_RANGE;
        end else begin
          pos = it.bit_index - shadow_base;
          if (it.operation == OP_TEST) begin
            r.bit_state = shadow_map[pos];
          end else begin
            shadow_map[pos] = it.set_value;
          end
        end
      end
      OP_SCAN: begin
        run = 0;
        first = 0;
        hit = 1'b0;
        if (it.run_length != 0) begin
          for (i = 0; i < total && !hit; i++) begin
            run = shadow_map[i] ? 0 : run + 1;
            if (run == it.run_length) begin
              first = i + 1 - it.run_length;
              hit = 1'b1;
            end
          end
        end
        if (hit) begin
          for (i = first; i < first + it.run_length; i++) shadow_map[i] = 1'b1;
          r.run_start = first + shadow_base;
        end else begin
          r.status = ST_NOT_FOUND;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] pick_index();
    int unsigned total;
    int unsigned sel;
    total = bits_used();
    sel = $urandom_range(0, 99);
    if (sel < 70 && total != 0) return shadow_base + $urandom_range(0, total - 1);
    if (sel < 80) return shadow_base - $urandom_range(1, 4);
    if (sel < 90) return shadow_base + total + $urandom_range(0, 4);
    return $urandom;
  endfunction

  function automatic logic [10:0] pick_length();
    int unsigned total;
    int unsigned sel;
    total = bits_used();
    sel = $urandom_range(0, 99);
    if (sel < 60) return 11'($urandom_range(1, 8));
    if (sel < 80) return 11'($urandom_range(1, 64));
    if (sel < 88) return (total == 0) ? 11'd1 : 11'($urandom_range(1, total));
    if (sel < 92) return '0;
    if (sel < 96) return 11'($urandom_range(1024, 2047));
    return 11'(total + $urandom_range(0, 3));
  endfunction

  task automatic send_beat(input logic [1:0] op, input logic [31:0] idx,
                           input logic val, input logic [10:0] len);
    item_t it;
    it = '{operation: op, bit_index: idx, set_value: val, run_length: len};
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    @(posedge clk);
    start <= 1'b1;
    item  <= it;
    do @(posedge clk); while (busy);
    start <= 1'b0;
    last_outcome = alloc_outcome(it);
    pending_results.push_back(last_outcome);
    beats_sent++;
  endtask

  task automatic wait_idle();
    while (pending_results.size() != 0 || busy) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    wait_idle();
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == REG_BASE_INDEX) begin
      shadow_base = data;
    end else begin
      shadow_bytes = data[7:0];
    end
  endtask

  task automatic report_mismatch(input string what, input result_t exp_r, input result_t got);
    mismatches++;
    if (mismatches <= MAX_SHOWN) begin
      $display("%t: %s: expected status %0d bit %0b start %h, got status %0d bit %0b start %h",
               $realtime, what, exp_r.status, exp_r.bit_state, exp_r.run_start,
               got.status, got.bit_state, got.run_start);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && done === 1'b1) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with none pending", '0, result);
      end else begin
        want = pending_results.pop_front();
        if (result.status !== want.status || result.bit_state !== want.bit_state ||
            result.run_start !== want.run_start) begin
          report_mismatch("result mismatch", want, result);
        end
      end
    end
  end

  task automatic test_reset_map();
    send_beat(OP_TEST, 32'd0, 1'b0, 11'd0);
    send_beat(OP_TEST, 32'd1023, 1'b1, 11'd0);
    send_beat(OP_TEST, 32'd1024, 1'b0, 11'd0);
    send_beat(OP_TEST, 32'hFFFF_FFFF, 1'b0, 11'd0);
    send_beat(OP_SCAN, 32'd0, 1'b0, 11'd0);
    send_beat(OP_UNUSED, 32'hFFFF_FFFF, 1'b1, 11'h7FF);
  endtask

  // Sender holds off after each of the first three beats until its result is back.
  task automatic test_bit_access();
    send_beat(OP_SET, 32'd0, 1'b1, 11'd0);
    wait_idle();
    send_beat(OP_TEST, 32'd0, 1'b0, 11'd0);
    wait_idle();
    send_beat(OP_SET, 32'd1023, 1'b1, 11'h7FF);
    wait_idle();
    send_beat(OP_TEST, 32'd1023, 1'b0, 11'd0);
    send_beat(OP_SET, 32'd1023, 1'b0, 11'd0);
    send_beat(OP_SET, 32'd2000, 1'b1, 11'd0);
  endtask

  task automatic test_config_extremes();
    write_reg(REG_BASE_INDEX, 32'hFFFF_FFFC);
    write_reg(REG_BYTES_IN_USE, 32'd1);
    send_beat(OP_SCAN, 32'd0, 1'b0, 11'd4);
    // run start plus base wraps past the top
    send_beat(OP_SCAN, 32'd0, 1'b0, 11'd3);
    send_beat(OP_TEST, 32'hFFFF_FFFB, 1'b0, 11'd0);
    send_beat(OP_TEST, 32'hFFFF_FFFF, 1'b0, 11'd0);
    send_beat(OP_SET, 32'd0, 1'b1, 11'd0);
    write_reg(REG_BYTES_IN_USE, 32'd0);
    send_beat(OP_TEST, 32'hFFFF_FFFC, 1'b0, 11'd0);
    send_beat(OP_SCAN, 32'd0, 1'b0, 11'd1);
    write_reg(REG_BASE_INDEX, 32'd0);
    // only the low byte counts, and 255 saturates to the full map
    write_reg(REG_BYTES_IN_USE, 32'hABCD_12FF);
    send_beat(OP_TEST, 32'd1023, 1'b0, 11'd0);
    send_beat(OP_TEST, 32'd1024, 1'b0, 11'd0);
  endtask

  task automatic test_run_scan();
    write_reg(REG_BYTES_IN_USE, {24'd0, BYTES_IN_USE_RESET});
    send_beat(OP_SCAN, 32'd0, 1'b0, 11'd1);
    send_beat(OP_SCAN, 32'hFFFF_FFFF, 1'b1, 11'd1015);
    send_beat(OP_SCAN, 32'd0, 1'b0, 11'd1);
    send_beat(OP_SCAN, 32'd0, 1'b0, 11'd1024);
    send_beat(OP_SCAN, 32'd0, 1'b0, 11'h7FF);
  endtask

  // Mostly allocate/release traffic, with tests and stray beats mixed in.
  task automatic test_random_phase(input logic [31:0] base, input logic [31:0] bytes_word,
                                   input int beats, input bit quiet);
    int          goal;
    int unsigned sel;
    int unsigned slot;
    int unsigned pos;
    int unsigned len;
    int unsigned k;
    write_reg(REG_BASE_INDEX, base);
    write_reg(REG_BYTES_IN_USE, bytes_word);
    live_pos.delete();
    live_len.delete();
    no_idle = quiet;
    goal = beats_sent + beats;
    while (beats_sent < goal) begin
      sel = $urandom_range(0, 99);
      if (sel < 45) begin
        len = {21'd0, pick_length()};
        send_beat(OP_SCAN, $urandom, 1'($urandom), 11'(len));
        if (last_outcome.status == ST_OK) begin
          live_pos.push_back(last_outcome.run_start - shadow_base);
          live_len.push_back(len);
        end
      end else if (sel < 65 && live_pos.size() != 0) begin
        slot = $urandom_range(0, live_pos.size() - 1);
        pos = live_pos[slot];
        len = live_len[slot];
        live_pos.delete(slot);
        live_len.delete(slot);
        // long runs are only partly released
        for (k = 0; k < len && k < 64; k++) begin
          send_beat(OP_SET, shadow_base + pos + k, 1'b0, 11'($urandom));
        end
      end else if (sel < 85) begin
        send_beat(OP_TEST, pick_index(), 1'($urandom), 11'($urandom));
      end else if (sel < 96) begin
        send_beat(OP_SET, pick_index(), 1'($urandom), 11'($urandom));
      end else begin
        send_beat(OP_UNUSED, $urandom, 1'($urandom), 11'($urandom));
      end
    end
  endtask

  initial begin
    rst       <= 1'b1;
    start     <= 1'b0;
    item      <= '0;
    cfg_write <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    foreach (shadow_map[i]) shadow_map[i] = 1'b0;
    shadow_base  = '0;
    shadow_bytes = BYTES_IN_USE_RESET;
    mismatches   = 0;
    beats_sent   = 0;
    no_idle      = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_reset_map();
    test_bit_access();
    test_config_extremes();
    test_run_scan();
    test_random_phase(32'd0, 32'd128, 300, 1'b0);
    test_random_phase($urandom, $urandom_range(1, 4), 250, 1'b0);
    test_random_phase(32'hFFFF_FFFF - $urandom_range(0, 63), 32'd16, 250, 1'b0);
    test_random_phase($urandom, ($urandom & 32'hFFFF_FF00) | 32'd200, 250, 1'b0);
    test_random_phase($urandom, 32'd0, 50, 1'b0);
    test_random_phase($urandom, $urandom_range(1, 255), 300, 1'b0);
    test_random_phase($urandom_range(0, 4095), 32'd8, 325, 1'b1);

    wait_idle();
    repeat (250) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("** bitmap_run_allocator: PASSED **");
    end else begin
      $display("** bitmap_run_allocator: FAILED **");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+sv
sv/bra_pkg.sv
sv/bra_dpath.sv
sv/bra_ctrl.sv
sv/bitmap_run_allocator.sv
sv/bra_chk.sv
tb/bitmap_run_allocator_test.sv
